@@ hdl/prm_pkg.sv @@
package prm_pkg;

    localparam int COUNT_BITS_DEFAULT    = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int TS_BITS               = 63;
    localparam int RATE_BITS             = 64;
    localparam int EV_BITS               = 32;
    localparam int FREQ_BITS             = 32;
    localparam logic [FREQ_BITS-1:0] FREQ_RESET = 32'd1000000000;

    typedef enum logic
    {
        CMD_RESTART = 1'b0,
        CMD_REPORT  = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_BACKWARDS = 2'd1,
        STATUS_TOTAL_OVF = 2'd2,
        STATUS_COUNT_OVF = 2'd3
    } status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_UPDATE,
        S_PEAK_MUL,
        S_PEAK_DIV,
        S_PEAK_WAIT,
        S_SUS_CHK,
        S_SUS_MUL,
        S_SUS_DIV,
        S_SUS_WAIT,
        S_DONE
    } state_t;

    typedef struct packed
    {
        command_t              command;
        logic [TS_BITS-1:0]    timestamp;
        logic [EV_BITS-1:0]    event_count;
    } in_item_t;

    typedef struct packed
    {
        status_t               status;
        logic [RATE_BITS-1:0]  peak_rate;
        logic                  peak_infinite;
        logic [RATE_BITS-1:0]  sustained_rate;
        logic                  sustained_undefined;
        logic [EV_BITS-1:0]    largest_burst;
        logic [EV_BITS-1:0]    report_total;
        logic [EV_BITS-1:0]    event_total;
    } out_item_t;

    typedef struct packed
    {
        logic                  start;
        logic [RATE_BITS-1:0]  dividend;
        logic [TS_BITS-1:0]    divisor;
    } div_req_t;

    typedef struct packed
    {
        logic                  done;
        logic [RATE_BITS-1:0]  quotient;
    } div_rsp_t;

endpackage

@@ hdl/prm_div.sv @@
module prm_div #(
    parameter int FRACTION_BITS = prm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  prm_pkg::div_req_t  req,
    output prm_pkg::div_rsp_t  rsp
);
    import prm_pkg::*;

    localparam int WIDE  = RATE_BITS + FRACTION_BITS;
    localparam int CNT_W = $clog2(RATE_BITS);

    logic [WIDE-1:0]      scaled;
    logic [RATE_BITS-1:0] head;
    logic [RATE_BITS-1:0] divisor_wide;
    logic                 saturate;
    logic [RATE_BITS-1:0] trial;
    logic [RATE_BITS-1:0] den_wide;
    logic                 fits;
    logic [RATE_BITS-1:0] diff;

    logic [RATE_BITS-1:0] rem_reg;
    logic [RATE_BITS-1:0] shift_reg;
    logic [TS_BITS-1:0]   den_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // The fraction bits above the 64-bit word are the starting remainder;
    // if they already reach the divisor the quotient cannot fit.
    assign scaled       = WIDE'(req.dividend) << FRACTION_BITS;
    assign head         = RATE_BITS'(scaled >> RATE_BITS);
    assign divisor_wide = {1'b0, req.divisor};
    assign saturate     = head >= divisor_wide;

    assign trial    = {rem_reg[RATE_BITS-2:0], shift_reg[RATE_BITS-1]};
    assign den_wide = {1'b0, den_reg};
    assign fits     = trial >= den_wide;
    assign diff     = trial - den_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                count_reg <= '0;
                if (saturate)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(RATE_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in at the bottom as the dividend bits leave the top.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= head;
            den_reg <= req.divisor;
            if (saturate)
            begin
                shift_reg <= '1;
            end
            else
            begin
                shift_reg <= scaled[RATE_BITS-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg   <= fits ? diff : trial;
            shift_reg <= {shift_reg[RATE_BITS-2:0], fits};
        end
    end

    always_comb
    begin
        rsp.done     = done_reg;
        rsp.quotient = shift_reg;
    end

endmodule

@@ hdl/peak_sustained_rate_meter.sv @@
// Peak and sustained event rate meter.
// Input channel (in_valid / in_stall / in_data): each transfer is a restart or
// an event report with a timestamp. Output channel (out_valid / out_stall /
// out_data): exactly one result per input transfer, in order. The tick
// frequency is written on the cfg channel (cfg_ready is always high) and must
// only be changed while no item is in flight.
// One item is handled at a time; in_stall is high from the transfer until the
// result is loaded into the output register. With no rate to divide (a restart,
// an empty event total, or no time elapsed since the restart) the sequencer
// runs only its update, check and final steps. Each rate that is divided adds
// a 32x32 multiply, a start step, the shared radix-2 divider (which skips its
// bit loop when the quotient saturates) and a handoff. The next input transfer
// can come in the cycle after the result is loaded.
// A finished result waits in the output register while out_stall is high; the
// sequencer holds in its final step until that register is free.
// Reset clears all meter state, sets the tick frequency to 1e9 and leaves the
// output channel empty.
module peak_sustained_rate_meter #(
    parameter int COUNT_BITS    = prm_pkg::COUNT_BITS_DEFAULT,
    parameter int FRACTION_BITS = prm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  prm_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output prm_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [prm_pkg::FREQ_BITS-1:0]    cfg_data
);
    import prm_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    state_t                state_reg, state_next;
    logic [FREQ_BITS-1:0]  freq_reg;

    command_t              cmd_reg;
    logic [TS_BITS-1:0]    ts_reg;
    logic [EV_BITS-1:0]    ev_reg;

    logic [TS_BITS-1:0]    start_reg, start_next;
    logic [TS_BITS-1:0]    last_reg, last_next;
    logic [RATE_BITS-1:0]  peak_reg, peak_next;
    logic                  inf_reg, inf_next;
    logic [COUNT_BITS-1:0] events_reg, events_next;
    logic [COUNT_BITS-1:0] burst_reg, burst_next;
    logic [COUNT_BITS-1:0] reports_reg, reports_next;

    status_t               status_reg, status_next;
    logic [TS_BITS-1:0]    delta_reg, delta_next;
    logic [RATE_BITS-1:0]  product_reg;
    logic [RATE_BITS-1:0]  sus_reg, sus_next;
    logic                  undef_reg, undef_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg;

    logic                  accept;
    logic                  load_out;
    logic                  mul_en;
    logic [EV_BITS-1:0]    mul_a;
    logic [RATE_BITS-1:0]  product;
    logic [COUNT_BITS-1:0] headroom;
    logic                  over_total;
    logic [COUNT_BITS-1:0] ev_narrow;
    logic                  ts_back;
    logic                  ts_same;
    logic                  sus_live;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    prm_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign headroom   = COUNT_MAX - events_reg;
    assign over_total = ev_reg > EV_BITS'(headroom);
    assign ev_narrow  = ev_reg[COUNT_BITS-1:0];
    assign ts_back    = ts_reg < last_reg;
    assign ts_same    = ts_reg == last_reg;
    assign sus_live   = last_reg > start_reg;

    // One multiplier serves both rates: events of this report, then the total.
    assign mul_en  = (state_reg == S_PEAK_MUL) || (state_reg == S_SUS_MUL);
    assign mul_a   = (state_reg == S_PEAK_MUL) ? ev_reg : EV_BITS'(events_reg);
    assign product = RATE_BITS'(mul_a) * RATE_BITS'(freq_reg);

    always_comb
    begin
        div_req.start    = (state_reg == S_PEAK_DIV) || (state_reg == S_SUS_DIV);
        div_req.dividend = product_reg;
        div_req.divisor  = delta_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        start_next   = start_reg;
        last_next    = last_reg;
        peak_next    = peak_reg;
        inf_next     = inf_reg;
        events_next  = events_reg;
        burst_next   = burst_reg;
        reports_next = reports_reg;
        status_next  = status_reg;
        delta_next   = delta_reg;
        sus_next     = sus_reg;
        undef_next   = undef_reg;
        load_out     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                status_next = STATUS_OK;
                delta_next  = ts_reg - last_reg;
                state_next  = S_SUS_CHK;
                if (cmd_reg == CMD_RESTART)
                begin
                    start_next   = ts_reg;
                    last_next    = ts_reg;
                    peak_next    = '0;
                    inf_next     = 1'b0;
                    events_next  = '0;
                    burst_next   = '0;
                    reports_next = '0;
                end
                else if (ts_back)
                begin
                    status_next = STATUS_BACKWARDS;
                end
                else if (ev_reg == '0)
                begin
                    last_next = ts_reg;
                end
                else if (over_total)
                begin
                    last_next   = ts_reg;
                    events_next = COUNT_MAX;
                    status_next = STATUS_TOTAL_OVF;
                end
                else if (reports_reg == COUNT_MAX)
                begin
                    last_next   = ts_reg;
                    status_next = STATUS_COUNT_OVF;
                end
                else if (events_reg == '0)
                begin
                    last_next    = ts_reg;
                    events_next  = ev_narrow;
                    burst_next   = ev_narrow;
                    reports_next = reports_reg + 1'b1;
                end
                else
                begin
                    // Once the peak is infinite it no longer changes.
                    if (ts_same)
                    begin
                        inf_next = 1'b1;
                    end
                    else if (!inf_reg)
                    begin
                        state_next = S_PEAK_MUL;
                    end
                    last_next    = ts_reg;
                    events_next  = events_reg + ev_narrow;
                    reports_next = reports_reg + 1'b1;
                    if (ev_narrow > burst_reg)
                    begin
                        burst_next = ev_narrow;
                    end
                end
            end

            S_PEAK_MUL:
            begin
                state_next = S_PEAK_DIV;
            end

            S_PEAK_DIV:
            begin
                state_next = S_PEAK_WAIT;
            end

            S_PEAK_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > peak_reg)
                    begin
                        peak_next = div_rsp.quotient;
                    end
                    state_next = S_SUS_CHK;
                end
            end

            S_SUS_CHK:
            begin
                delta_next = last_reg - start_reg;
                sus_next   = '0;
                undef_next = (events_reg != '0) && !sus_live;
                if ((events_reg != '0) && sus_live)
                begin
                    state_next = S_SUS_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SUS_MUL:
            begin
                state_next = S_SUS_DIV;
            end

            S_SUS_DIV:
            begin
                state_next = S_SUS_WAIT;
            end

            S_SUS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    sus_next   = div_rsp.quotient;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            freq_reg      <= FREQ_RESET;
            start_reg     <= '0;
            last_reg      <= '0;
            peak_reg      <= '0;
            inf_reg       <= 1'b0;
            events_reg    <= '0;
            burst_reg     <= '0;
            reports_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            peak_reg      <= peak_next;
            inf_reg       <= inf_next;
            events_reg    <= events_next;
            burst_reg     <= burst_next;
            reports_reg   <= reports_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                freq_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        delta_reg  <= delta_next;
        sus_reg    <= sus_next;
        undef_reg  <= undef_next;
        if (accept)
        begin
            cmd_reg <= in_data.command;
            ts_reg  <= in_data.timestamp;
            ev_reg  <= in_data.event_count;
        end
        if (mul_en)
        begin
            product_reg <= product;
        end
        if (load_out)
        begin
            out_reg.status              <= status_reg;
            out_reg.peak_rate           <= inf_reg ? '1 : peak_reg;
            out_reg.peak_infinite       <= inf_reg;
            out_reg.sustained_rate      <= sus_reg;
            out_reg.sustained_undefined <= undef_reg;
            out_reg.largest_burst       <= EV_BITS'(burst_reg);
            out_reg.report_total        <= EV_BITS'(reports_reg);
            out_reg.event_total         <= EV_BITS'(events_reg);
        end
    end

endmodule
